// ===== rtl/text_glyph_pixel_writer_assert.svh =====
// ----------------------------------------------------------------------------
// text_glyph_pixel_writer_assert.svh
// Assertion macros used by the checker file of the glyph pixel writer.
// ----------------------------------------------------------------------------
`ifndef TEXT_GLYPH_PIXEL_WRITER_ASSERT_SVH
`define TEXT_GLYPH_PIXEL_WRITER_ASSERT_SVH

// Same-cycle implication, sampled on clk, off while rst is high.
`define TGPW_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, off while rst is high.
`define TGPW_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/tgpw_pkg.sv =====
// ----------------------------------------------------------------------------
// tgpw_pkg
// Types, constants and the 5x7 font table of the glyph pixel writer.
// ----------------------------------------------------------------------------
package tgpw_pkg;

  localparam int GLYPH_WIDTH  = 5;
  localparam int GLYPH_HEIGHT = 7;
  localparam int COORD_BITS   = 16;
  localparam int CELL_COUNT   = GLYPH_WIDTH * GLYPH_HEIGHT;
  localparam int COL_BITS     = $clog2(GLYPH_WIDTH);
  localparam int ROW_BITS     = $clog2(GLYPH_HEIGHT);
  localparam int CHAR_ADVANCE = GLYPH_WIDTH + 2;
  localparam int LINE_ADVANCE = GLYPH_HEIGHT + 1;
  localparam int QUEUE_DEPTH  = 2;
  localparam int COLOR_BITS   = 24;
  localparam int ADDR_BITS    = 32;
  localparam int WIDTH_BITS   = 16;

  localparam logic [WIDTH_BITS-1:0] IMAGE_WIDTH_RESET = 16'd640;
  localparam logic [7:0]            CHAR_NEWLINE      = 8'h0A;

  typedef logic [COORD_BITS-1:0] coord_t;
  typedef logic [CELL_COUNT-1:0] glyph_bits_t;
  typedef logic [COLOR_BITS-1:0] color_t;

  // One drawing job for the back end: glyph origin, cell mask and ink.
  typedef struct packed {
    coord_t      cursor_x;
    coord_t      cursor_y;
    glyph_bits_t bits;
    color_t      color;
  } glyph_cmd_t;

  // Cell mask with row 0 in the top five bits; within a row the MSB is
  // column 0. Every glyph has at least one set cell, so zero means "not in
  // the font".
  function automatic glyph_bits_t font_lookup(input logic [7:0] code);
    glyph_bits_t bits;
    unique case (code)
      "A": bits = {5'h1F, 5'h11, 5'h11, 5'h1F, 5'h11, 5'h11, 5'h11};
      "B": bits = {5'h1E, 5'h11, 5'h11, 5'h1E, 5'h11, 5'h11, 5'h1E};
      "C": bits = {5'h0F, 5'h10, 5'h10, 5'h10, 5'h10, 5'h10, 5'h0F};
      "D": bits = {5'h1E, 5'h11, 5'h11, 5'h11, 5'h11, 5'h11, 5'h1E};
      "E": bits = {5'h1F, 5'h10, 5'h10, 5'h1F, 5'h10, 5'h10, 5'h1F};
      "F": bits = {5'h1F, 5'h10, 5'h10, 5'h1F, 5'h10, 5'h10, 5'h10};
      "G": bits = {5'h1F, 5'h10, 5'h10, 5'h13, 5'h11, 5'h11, 5'h1F};
      "H": bits = {5'h11, 5'h11, 5'h11, 5'h1F, 5'h11, 5'h11, 5'h11};
      "I": bits = {5'h1F, 5'h04, 5'h04, 5'h04, 5'h04, 5'h04, 5'h1F};
      "J": bits = {5'h1F, 5'h02, 5'h02, 5'h02, 5'h02, 5'h12, 5'h0C};
      "K": bits = {5'h11, 5'h12, 5'h14, 5'h18, 5'h14, 5'h12, 5'h11};
      "L": bits = {5'h10, 5'h10, 5'h10, 5'h10, 5'h10, 5'h10, 5'h1F};
      "M": bits = {5'h1F, 5'h15, 5'h15, 5'h15, 5'h15, 5'h11, 5'h11};
      "N": bits = {5'h11, 5'h19, 5'h19, 5'h15, 5'h13, 5'h13, 5'h11};
      "O": bits = {5'h1F, 5'h11, 5'h11, 5'h11, 5'h11, 5'h11, 5'h1F};
      "P": bits = {5'h1F, 5'h11, 5'h11, 5'h1F, 5'h10, 5'h10, 5'h10};
      "Q": bits = {5'h1F, 5'h11, 5'h11, 5'h11, 5'h11, 5'h1E, 5'h01};
      "R": bits = {5'h1F, 5'h11, 5'h11, 5'h1F, 5'h14, 5'h12, 5'h11};
      "S": bits = {5'h1F, 5'h10, 5'h10, 5'h1F, 5'h01, 5'h01, 5'h1F};
      "T": bits = {5'h1F, 5'h04, 5'h04, 5'h04, 5'h04, 5'h04, 5'h04};
      "U": bits = {5'h11, 5'h11, 5'h11, 5'h11, 5'h11, 5'h11, 5'h1F};
      "V": bits = {5'h11, 5'h11, 5'h11, 5'h11, 5'h11, 5'h11, 5'h0E};
      "W": bits = {5'h11, 5'h11, 5'h11, 5'h15, 5'h15, 5'h15, 5'h1F};
      "X": bits = {5'h11, 5'h0A, 5'h0A, 5'h04, 5'h0A, 5'h0A, 5'h11};
      "Y": bits = {5'h11, 5'h11, 5'h11, 5'h1F, 5'h04, 5'h04, 5'h04};
      "Z": bits = {5'h1F, 5'h01, 5'h02, 5'h02, 5'h04, 5'h08, 5'h1F};
      "0": bits = {5'h1F, 5'h19, 5'h15, 5'h15, 5'h15, 5'h13, 5'h1F};
      "1": bits = {5'h0C, 5'h14, 5'h04, 5'h04, 5'h04, 5'h04, 5'h1F};
      "2": bits = {5'h0E, 5'h11, 5'h01, 5'h02, 5'h0C, 5'h10, 5'h1F};
      "3": bits = {5'h1E, 5'h01, 5'h01, 5'h06, 5'h01, 5'h01, 5'h1E};
      "4": bits = {5'h03, 5'h09, 5'h11, 5'h1F, 5'h01, 5'h01, 5'h01};
      "5": bits = {5'h1F, 5'h10, 5'h10, 5'h1E, 5'h01, 5'h01, 5'h1E};
      "6": bits = {5'h0F, 5'h10, 5'h10, 5'h1E, 5'h11, 5'h11, 5'h0E};
      "7": bits = {5'h1F, 5'h01, 5'h02, 5'h02, 5'h04, 5'h08, 5'h10};
      "8": bits = {5'h0E, 5'h11, 5'h11, 5'h0E, 5'h11, 5'h11, 5'h0E};
      "9": bits = {5'h0E, 5'h11, 5'h11, 5'h0F, 5'h01, 5'h01, 5'h1E};
      ":": bits = {5'h00, 5'h04, 5'h04, 5'h00, 5'h04, 5'h04, 5'h00};
      ".": bits = {5'h00, 5'h00, 5'h00, 5'h00, 5'h00, 5'h18, 5'h18};
      "-": bits = {5'h00, 5'h00, 5'h00, 5'h1F, 5'h00, 5'h00, 5'h00};
      "[": bits = {5'h1F, 5'h10, 5'h10, 5'h10, 5'h10, 5'h10, 5'h1F};
      "]": bits = {5'h1F, 5'h01, 5'h01, 5'h01, 5'h01, 5'h01, 5'h1F};
      ",": bits = {5'h00, 5'h00, 5'h00, 5'h00, 5'h00, 5'h08, 5'h18};
      "!": bits = {5'h04, 5'h04, 5'h04, 5'h04, 5'h04, 5'h00, 5'h04};
      default: bits = '0;
    endcase
    return bits;
  endfunction

endpackage

// ===== rtl/tgpw_front.sv =====
// ----------------------------------------------------------------------------
// tgpw_front
// Takes characters, keeps the text cursor and issues glyph drawing jobs.
// ----------------------------------------------------------------------------
module tgpw_front
  import tgpw_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] char_code,
  input  logic       start_string,
  input  logic [15:0] origin_x,
  input  logic [15:0] origin_y,
  input  logic [23:0] ink_color,
  output logic       cmd_valid,
  output glyph_cmd_t cmd,
  input  logic       cmd_ready
);

  coord_t      cursor_x, cursor_x_next;
  coord_t      cursor_y, cursor_y_next;
  coord_t      line_start_x, line_start_x_next;
  coord_t      base_x, base_y, base_ls;
  glyph_bits_t bits;
  logic        accept;
  logic        is_newline;

  assign in_ready = cmd_ready;
  assign accept   = in_valid && in_ready;

  always_comb begin
    base_x     = start_string ? origin_x[COORD_BITS-1:0] : cursor_x;
    base_ls    = start_string ? origin_x[COORD_BITS-1:0] : line_start_x;
    base_y     = start_string ? origin_y[COORD_BITS-1:0] : cursor_y;
    bits       = font_lookup(char_code);
    is_newline = (char_code == CHAR_NEWLINE);

    cursor_x_next     = cursor_x;
    cursor_y_next     = cursor_y;
    line_start_x_next = line_start_x;
    if (accept) begin
      line_start_x_next = base_ls;
      if (is_newline) begin
        cursor_x_next = base_ls;
        cursor_y_next = base_y + COORD_BITS'(LINE_ADVANCE);
      end else begin
        cursor_x_next = base_x + COORD_BITS'(CHAR_ADVANCE);
        cursor_y_next = base_y;
      end
    end

    // Drop spaces, newlines and unknown codes: they only move the cursor
    cmd_valid     = accept && !is_newline && (bits != '0);
    cmd.cursor_x  = base_x;
    cmd.cursor_y  = base_y;
    cmd.bits      = bits;
    cmd.color     = ink_color[COLOR_BITS-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cursor_x     <= '0;
      cursor_y     <= '0;
      line_start_x <= '0;
    end else begin
      cursor_x     <= cursor_x_next;
      cursor_y     <= cursor_y_next;
      line_start_x <= line_start_x_next;
    end
  end

endmodule

// ===== rtl/tgpw_queue.sv =====
// ----------------------------------------------------------------------------
// tgpw_queue
// Short job queue between the cursor front end and the glyph scanner.
// ----------------------------------------------------------------------------
module tgpw_queue
  import tgpw_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       push_valid,
  input  glyph_cmd_t push_data,
  output logic       push_ready,
  output logic       pop_valid,
  output glyph_cmd_t pop_data,
  input  logic       pop_ready
);

  localparam int PTR_BITS = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_BITS = $clog2(QUEUE_DEPTH + 1);

  glyph_cmd_t          entries [QUEUE_DEPTH];
  logic [PTR_BITS-1:0] wr_ptr, rd_ptr;
  logic [CNT_BITS-1:0] count;
  logic                do_push, do_pop;

  function automatic logic [PTR_BITS-1:0] ptr_inc(input logic [PTR_BITS-1:0] p);
    return (p == PTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  assign push_ready = (count != CNT_BITS'(QUEUE_DEPTH));
  assign pop_valid  = (count != '0);
  assign pop_data   = entries[rd_ptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) wr_ptr <= ptr_inc(wr_ptr);
      if (do_pop)  rd_ptr <= ptr_inc(rd_ptr);
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) entries[wr_ptr] <= push_data;
  end

endmodule

// ===== rtl/tgpw_back.sv =====
// ----------------------------------------------------------------------------
// tgpw_back
// Scans one glyph cell per cycle while its output is not stalled, and emits a pixel write for each set cell.
// ----------------------------------------------------------------------------
module tgpw_back
  import tgpw_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        cmd_valid,
  input  glyph_cmd_t  cmd,
  output logic        cmd_ready,
  input  logic [15:0] image_width,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [15:0] pixel_x,
  output logic [15:0] pixel_y,
  output logic [31:0] pixel_address,
  output logic [23:0] pixel_color,
  output logic        last_pixel
);

  logic                busy;
  glyph_bits_t         bits;
  logic [COL_BITS-1:0] col;
  logic [ROW_BITS-1:0] row;
  coord_t              base_x, base_y;
  color_t              color;

  logic                step, cur_bit, rest_empty, finish, load;
  coord_t              px, py;
  logic [ADDR_BITS-1:0] py_ext, w_ext, prod, addr;

  assign step       = busy && (!out_valid || out_ready);
  assign cur_bit    = bits[CELL_COUNT-1];
  assign rest_empty = (bits[CELL_COUNT-2:0] == '0);
  assign finish     = step && cur_bit && rest_empty;
  assign cmd_ready  = !busy || finish;
  assign load       = cmd_valid && cmd_ready;

  assign px     = base_x + COORD_BITS'(col);
  assign py     = base_y + COORD_BITS'(row);
  assign py_ext = ADDR_BITS'(py);
  assign w_ext  = ADDR_BITS'(image_width);
  assign prod   = py_ext * w_ext;
  assign addr   = ADDR_BITS'(px) + prod;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy      <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && out_ready) out_valid <= 1'b0;
      if (step && cur_bit)        out_valid <= 1'b1;
      if (load) begin
        busy <= 1'b1;
      end else if (finish) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      bits   <= cmd.bits;
      col    <= '0;
      row    <= '0;
      base_x <= cmd.cursor_x;
      base_y <= cmd.cursor_y;
      color  <= cmd.color;
    end else if (step) begin
      bits <= bits << 1;
      if (col == COL_BITS'(GLYPH_WIDTH - 1)) begin
        col <= '0;
        row <= row + 1'b1;
      end else begin
        col <= col + 1'b1;
      end
    end
    if (step && cur_bit) begin
      pixel_x       <= 16'(px);
      pixel_y       <= 16'(py);
      pixel_address <= addr;
      pixel_color   <= color;
      last_pixel    <= rest_empty;
    end
  end

endmodule

// ===== rtl/text_glyph_pixel_writer.sv =====
// ----------------------------------------------------------------------------
// text_glyph_pixel_writer
// Text overlay character generator: 5x7 font, cursor, pixel write stream.
// ----------------------------------------------------------------------------
// Pipeline: each glyph job passes through the job queue and the scanner's job
//   registers before its first pixel write is registered; blank cells that lead
//   the glyph are scanned first. The scanner visits one glyph cell per cycle while
//   the output is not stalled, up to the last set cell; space, newline and unknown
//   codes make no job. A 2-deep job queue lets input run ahead.
// Reset (rst, synchronous): cursor and line start to zero, image width 640,
//   queue and scanner empty.
// ----------------------------------------------------------------------------
module text_glyph_pixel_writer
  import tgpw_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  // configuration: image width, written without handshake
  input  logic        cfg_write_en,
  input  logic [15:0] cfg_write_data,
  // character transfer in
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  char_code,
  input  logic        start_string,
  input  logic [15:0] origin_x,
  input  logic [15:0] origin_y,
  input  logic [23:0] ink_color,
  // pixel write transfer out
  output logic        out_valid,
  input  logic        out_ready,
  output logic [15:0] pixel_x,
  output logic [15:0] pixel_y,
  output logic [31:0] pixel_address,
  output logic [23:0] pixel_color,
  output logic        last_pixel
);

  logic [WIDTH_BITS-1:0] image_width;

  logic       front_valid, front_ready;
  glyph_cmd_t front_cmd;
  logic       back_valid, back_ready;
  glyph_cmd_t back_cmd;

  // Hold the row pitch. The user must send writes only while the block is idle;
  // the block does not enforce this, and the scanner reads it directly.
  always_ff @(posedge clk) begin
    if (rst) begin
      image_width <= IMAGE_WIDTH_RESET;
    end else if (cfg_write_en) begin
      image_width <= cfg_write_data;
    end
  end

  // Front end: apply string start, newline and advance to the cursor, and
  // turn each drawable character into a job.
  tgpw_front u_front (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .char_code    (char_code),
    .start_string (start_string),
    .origin_x     (origin_x),
    .origin_y     (origin_y),
    .ink_color    (ink_color),
    .cmd_valid    (front_valid),
    .cmd          (front_cmd),
    .cmd_ready    (front_ready)
  );

  // Decouple the two halves so the cursor keeps moving during a scan while the queue has room.
  tgpw_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (front_valid),
    .push_data  (front_cmd),
    .push_ready (front_ready),
    .pop_valid  (back_valid),
    .pop_data   (back_cmd),
    .pop_ready  (back_ready)
  );

  // Back end: walk the glyph row by row, left to right, and register each
  // pixel write with its linear address.
  tgpw_back u_back (
    .clk           (clk),
    .rst           (rst),
    .cmd_valid     (back_valid),
    .cmd           (back_cmd),
    .cmd_ready     (back_ready),
    .image_width   (image_width),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .pixel_x       (pixel_x),
    .pixel_y       (pixel_y),
    .pixel_address (pixel_address),
    .pixel_color   (pixel_color),
    .last_pixel    (last_pixel)
  );

endmodule

// ===== rtl/tgpw_checker.sv =====
// ----------------------------------------------------------------------------
// tgpw_checker
// Port-level checks of the glyph pixel writer, bound to the top level.
// ----------------------------------------------------------------------------
`include "text_glyph_pixel_writer_assert.svh"

module tgpw_checker
  import tgpw_pkg::*;
(
  input logic        clk,
  input logic        rst,
  input logic        cfg_write_en,
  input logic [15:0] cfg_write_data,
  input logic        out_valid,
  input logic        out_ready,
  input logic [15:0] pixel_x,
  input logic [15:0] pixel_y,
  input logic [31:0] pixel_address,
  input logic [23:0] pixel_color,
  input logic        last_pixel
);

  logic [15:0] width_seen;
  logic        mid_char;
  logic [23:0] prev_color;
  logic [15:0] prev_y;
  logic [15:0] row_step;
  logic [31:0] addr_expect;
  logic        out_xfer;

  assign out_xfer    = out_valid && out_ready;
  assign row_step    = pixel_y - prev_y;
  assign addr_expect = 32'(pixel_x) + 32'(pixel_y) * 32'(width_seen);

  // Track the pitch and the previous pixel of the character being drawn
  always_ff @(posedge clk) begin
    if (rst) begin
      width_seen <= IMAGE_WIDTH_RESET;
      mid_char   <= 1'b0;
    end else begin
      if (cfg_write_en) width_seen <= cfg_write_data;
      if (out_xfer)     mid_char   <= !last_pixel;
    end
  end

  always_ff @(posedge clk) begin
    if (out_xfer) begin
      prev_color <= pixel_color;
      prev_y     <= pixel_y;
    end
  end

  `TGPW_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(pixel_address) && $stable(last_pixel), "pixel write changed while stalled")
  `TGPW_ASSERT_NOW(a_addr, out_valid, pixel_address == addr_expect, "pixel address does not match x + y * width")
  `TGPW_ASSERT_NOW(a_color, out_valid && mid_char, pixel_color == prev_color, "colour changed within one character")
  `TGPW_ASSERT_NOW(a_rows, out_valid && mid_char, row_step < 16'(GLYPH_HEIGHT), "pixel row left the glyph cell")

endmodule

bind text_glyph_pixel_writer tgpw_checker u_tgpw_checker (.*);

// ===== tb/text_glyph_pixel_writer_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// text_glyph_pixel_writer_test
// Self-checking bench for the glyph pixel writer. A local glyph table and
// cursor model work out the pixel writes of every accepted character. Each
// pixel transfer out is compared field by field with the oldest expected
// write. The stimulus is a directed pass, a sweep of image widths, a long
// output hold-off and a random text stream with random idling on both
// handshakes.
// ----------------------------------------------------------------------------
module text_glyph_pixel_writer_test;
  import tgpw_pkg::*;

  localparam int IDLE_PERCENT    = 30;
  localparam int RESET_CYCLES    = 7;
  localparam int SETTLE_CYCLES   = 40;     // scanner plus 2-deep queue, with margin
  localparam int HOLD_OFF_CYCLES = 400;
  localparam int RANDOM_ITEMS    = 180;
  localparam int QUIET_ITEMS     = 60;     // opening stretch with no idling
  localparam int FONT_SIZE       = 43;
  localparam int TIMEOUT_NS      = 1_000_000;

  localparam logic [7:0] CHAR_SPACE   = " ";
  localparam logic [7:0] CHAR_LOWER_A = "a";
  localparam logic [7:0] CHAR_LOWER_Z = "z";
  localparam logic [7:0] CHAR_NUL     = 8'h00;
  localparam logic [7:0] CHAR_TOP     = 8'hFF;

  typedef logic [ADDR_BITS-1:0] addr_t;

  typedef struct packed {
    logic [7:0] code;
    logic       start;
    coord_t     org_x;
    coord_t     org_y;
    color_t     ink;
  } char_item_t;

  typedef struct packed {
    coord_t x;
    coord_t y;
    addr_t  addr;
    color_t color;
    logic   last;
  } pixel_write_t;

  logic        clk;
  logic        rst;
  logic        cfg_write_en;
  logic [15:0] cfg_write_data;
  logic        in_valid;
  logic        in_ready;
  logic [7:0]  char_code;
  logic        start_string;
  logic [15:0] origin_x;
  logic [15:0] origin_y;
  logic [23:0] ink_color;
  logic        out_valid;
  logic        out_ready;
  logic [15:0] pixel_x;
  logic [15:0] pixel_y;
  logic [31:0] pixel_address;
  logic [23:0] pixel_color;
  logic        last_pixel;

  // Cursor model and image width as the block should hold them
  coord_t                pen_x;
  coord_t                pen_y;
  coord_t                margin_x;
  logic [WIDTH_BITS-1:0] row_pitch;

  pixel_write_t pending_pixels[$];

  // Glyph table: code in the top byte, then rows 0..6, column 0 in each MSB
  logic [42:0] font_rows [FONT_SIZE];

  bit source_gaps_on;
  bit sink_stalls_on;
  bit sink_hold_req;

  int mismatch_count;
  int pixels_checked;
  int chars_sent;
  int width_writes;

  text_glyph_pixel_writer u_top (
    .clk            (clk),
    .rst            (rst),
    .cfg_write_en   (cfg_write_en),
    .cfg_write_data (cfg_write_data),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .char_code      (char_code),
    .start_string   (start_string),
    .origin_x       (origin_x),
    .origin_y       (origin_y),
    .ink_color      (ink_color),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .pixel_x        (pixel_x),
    .pixel_y        (pixel_y),
    .pixel_address  (pixel_address),
    .pixel_color    (pixel_color),
    .last_pixel     (last_pixel)
  );

  always #1 clk = ~clk;

  initial begin : load_font
    font_rows = '{
      {"A", 5'h1F, 5'h11, 5'h11, 5'h1F, 5'h11, 5'h11, 5'h11},
      {"B", 5'h1E, 5'h11, 5'h11, 5'h1E, 5'h11, 5'h11, 5'h1E},
      {"C", 5'h0F, 5'h10, 5'h10, 5'h10, 5'h10, 5'h10, 5'h0F},
      {"D", 5'h1E, 5'h11, 5'h11, 5'h11, 5'h11, 5'h11, 5'h1E},
      {"E", 5'h1F, 5'h10, 5'h10, 5'h1F, 5'h10, 5'h10, 5'h1F},
      {"F", 5'h1F, 5'h10, 5'h10, 5'h1F, 5'h10, 5'h10, 5'h10},
      {"G", 5'h1F, 5'h10, 5'h10, 5'h13, 5'h11, 5'h11, 5'h1F},
      {"H", 5'h11, 5'h11, 5'h11, 5'h1F, 5'h11, 5'h11, 5'h11},
      {"I", 5'h1F, 5'h04, 5'h04, 5'h04, 5'h04, 5'h04, 5'h1F},
      {"J", 5'h1F, 5'h02, 5'h02, 5'h02, 5'h02, 5'h12, 5'h0C},
      {"K", 5'h11, 5'h12, 5'h14, 5'h18, 5'h14, 5'h12, 5'h11},
      {"L", 5'h10, 5'h10, 5'h10, 5'h10, 5'h10, 5'h10, 5'h1F},
      {"M", 5'h1F, 5'h15, 5'h15, 5'h15, 5'h15, 5'h11, 5'h11},
      {"N", 5'h11, 5'h19, 5'h19, 5'h15, 5'h13, 5'h13, 5'h11},
      {"O", 5'h1F, 5'h11, 5'h11, 5'h11, 5'h11, 5'h11, 5'h1F},
      {"P", 5'h1F, 5'h11, 5'h11, 5'h1F, 5'h10, 5'h10, 5'h10},
      {"Q", 5'h1F, 5'h11, 5'h11, 5'h11, 5'h11, 5'h1E, 5'h01},
      {"R", 5'h1F, 5'h11, 5'h11, 5'h1F, 5'h14, 5'h12, 5'h11},
      {"S", 5'h1F, 5'h10, 5'h10, 5'h1F, 5'h01, 5'h01, 5'h1F},
      {"T", 5'h1F, 5'h04, 5'h04, 5'h04, 5'h04, 5'h04, 5'h04},
      {"U", 5'h11, 5'h11, 5'h11, 5'h11, 5'h11, 5'h11, 5'h1F},
      {"V", 5'h11, 5'h11, 5'h11, 5'h11, 5'h11, 5'h11, 5'h0E},
      {"W", 5'h11, 5'h11, 5'h11, 5'h15, 5'h15, 5'h15, 5'h1F},
      {"X", 5'h11, 5'h0A, 5'h0A, 5'h04, 5'h0A, 5'h0A, 5'h11},
      {"Y", 5'h11, 5'h11, 5'h11, 5'h1F, 5'h04, 5'h04, 5'h04},
      {"Z", 5'h1F, 5'h01, 5'h02, 5'h02, 5'h04, 5'h08, 5'h1F},
      {"0", 5'h1F, 5'h19, 5'h15, 5'h15, 5'h15, 5'h13, 5'h1F},
      {"1", 5'h0C, 5'h14, 5'h04, 5'h04, 5'h04, 5'h04, 5'h1F},
      {"2", 5'h0E, 5'h11, 5'h01, 5'h02, 5'h0C, 5'h10, 5'h1F},
      {"3", 5'h1E, 5'h01, 5'h01, 5'h06, 5'h01, 5'h01, 5'h1E},
      {"4", 5'h03, 5'h09, 5'h11, 5'h1F, 5'h01, 5'h01, 5'h01},
      {"5", 5'h1F, 5'h10, 5'h10, 5'h1E, 5'h01, 5'h01, 5'h1E},
      {"6", 5'h0F, 5'h10, 5'h10, 5'h1E, 5'h11, 5'h11, 5'h0E},
      {"7", 5'h1F, 5'h01, 5'h02, 5'h02, 5'h04, 5'h08, 5'h10},
      {"8", 5'h0E, 5'h11, 5'h11, 5'h0E, 5'h11, 5'h11, 5'h0E},
      {"9", 5'h0E, 5'h11, 5'h11, 5'h0F, 5'h01, 5'h01, 5'h1E},
      {":", 5'h00, 5'h04, 5'h04, 5'h00, 5'h04, 5'h04, 5'h00},
      {".", 5'h00, 5'h00, 5'h00, 5'h00, 5'h00, 5'h18, 5'h18},
      {"-", 5'h00, 5'h00, 5'h00, 5'h1F, 5'h00, 5'h00, 5'h00},
      {"[", 5'h1F, 5'h10, 5'h10, 5'h10, 5'h10, 5'h10, 5'h1F},
      {"]", 5'h1F, 5'h01, 5'h01, 5'h01, 5'h01, 5'h01, 5'h1F},
      {",", 5'h00, 5'h00, 5'h00, 5'h00, 5'h00, 5'h08, 5'h18},
      {"!", 5'h04, 5'h04, 5'h04, 5'h04, 5'h04, 5'h00, 5'h04}
    };
  end

  // Cell mask of a code; all zero when the code has no glyph
  function automatic glyph_bits_t glyph_cells(input logic [7:0] code);
    for (int i = 0; i < FONT_SIZE; i++) begin
      if (font_rows[i][42:35] == code) return font_rows[i][34:0];
    end
    return '0;
  endfunction

  // Work out the pixel writes of one accepted character and advance the cursor
  function automatic void draw_char_pixels(input char_item_t item);
    glyph_bits_t  cells;
    pixel_write_t px;
    int           remaining;
    // Load the origin first, so a newline with the start flag lands at origin_y + 8
    if (item.start) begin
      pen_x    = item.org_x;
      margin_x = item.org_x;
      pen_y    = item.org_y;
    end
    if (item.code == CHAR_NEWLINE) begin
      pen_x = margin_x;
      pen_y = pen_y + coord_t'(LINE_ADVANCE);
      return;
    end
    cells     = glyph_cells(item.code);
    remaining = $countones(cells);
    // Scan rows top down, columns left to right; coordinates wrap at 16 bits
    for (int row = 0; row < GLYPH_HEIGHT; row++) begin
      for (int col = 0; col < GLYPH_WIDTH; col++) begin
        if (cells[CELL_COUNT - 1 - (row * GLYPH_WIDTH + col)]) begin
          remaining--;
          px.x     = pen_x + coord_t'(col);
          px.y     = pen_y + coord_t'(row);
          px.addr  = addr_t'(px.x) + addr_t'(px.y) * addr_t'(row_pitch);
          px.color = item.ink;
          px.last  = (remaining == 0);
          pending_pixels.push_back(px);
        end
      end
    end
    // Space and unknown codes fall through here with no pixels: advance only
    pen_x = pen_x + coord_t'(CHAR_ADVANCE);
  endfunction

  function automatic char_item_t make_item(input logic [7:0] code, input logic start,
                                           input coord_t ox, input coord_t oy,
                                           input color_t ink);
    char_item_t item;
    item.code  = code;
    item.start = start;
    item.org_x = ox;
    item.org_y = oy;
    item.ink   = ink;
    return item;
  endfunction

  // Origins: plain random, or hugging either end of the coordinate range
  function automatic coord_t random_origin();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 20) return coord_t'($urandom_range(16'hFFC0, 16'hFFFF));
    if (roll < 35) return coord_t'($urandom_range(0, 63));
    return coord_t'($urandom());
  endfunction

  // Mostly glyphs, with spaces, newlines and codes outside the font mixed in
  function automatic logic [7:0] random_char();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 72) return font_rows[$urandom_range(0, FONT_SIZE - 1)][42:35];
    if (roll < 82) return CHAR_SPACE;
    if (roll < 89) return CHAR_NEWLINE;
    if (roll < 94) return 8'($urandom_range(CHAR_LOWER_A, CHAR_LOWER_Z));
    return 8'($urandom_range(0, 255));
  endfunction

  // Offer one character and hold it until the transfer; valid is only dropped
  // for an idle gap, so back-to-back items keep it high.
  task automatic send_char(input char_item_t item);
    @(negedge clk);
    if (source_gaps_on) begin
      while ($urandom_range(0, 99) < IDLE_PERCENT) begin
        in_valid <= 1'b0;
        @(negedge clk);
      end
    end
    in_valid     <= 1'b1;
    char_code    <= item.code;
    start_string <= item.start;
    origin_x     <= item.org_x;
    origin_y     <= item.org_y;
    ink_color    <= item.ink;
    do @(posedge clk); while (in_ready !== 1'b1);
    draw_char_pixels(item);
    chars_sent++;
  endtask

  // Drop valid and hold until every expected pixel is out, then let the
  // scanner settle before returning.
  task automatic wait_for_pixels();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_pixels.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_image_width(input logic [WIDTH_BITS-1:0] width);
    wait_for_pixels();
    @(negedge clk);
    cfg_write_en   <= 1'b1;
    cfg_write_data <= width;
    @(negedge clk);
    cfg_write_en   <= 1'b0;
    row_pitch = width;
    width_writes++;
  endtask

  // One string of random text; now and then it carries on from the previous
  // cursor, or reloads the origin mid-string.
  task automatic send_random_string(input int length);
    char_item_t item;
    for (int i = 0; i < length; i++) begin
      item.code  = random_char();
      item.start = (i == 0) ? ($urandom_range(0, 99) >= 10) : ($urandom_range(0, 99) < 4);
      item.org_x = random_origin();
      item.org_y = random_origin();
      item.ink   = color_t'($urandom());
      send_char(item);
    end
  endtask

  // Receiver: hold off on request, otherwise stall at random when enabled
  initial begin : pixel_sink
    int hold_left;
    hold_left = 0;
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (sink_hold_req) begin
        sink_hold_req = 1'b0;
        hold_left     = HOLD_OFF_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else if (sink_stalls_on) begin
        out_ready <= ($urandom_range(0, 99) >= IDLE_PERCENT);
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // Compare every pixel transfer with the oldest expected write
  always @(posedge clk) begin : pixel_check
    pixel_write_t want;
    if (!rst && out_valid === 1'b1 && out_ready === 1'b1) begin
      if (pending_pixels.size() == 0) begin
        $error("unexpected pixel write: pixel_x %0d pixel_y %0d", pixel_x, pixel_y);
        mismatch_count++;
      end else begin
        want = pending_pixels.pop_front();
        pixels_checked++;
        if (pixel_x !== want.x) begin
          $error("pixel_x: expected %0d, got %0d", want.x, pixel_x);
          mismatch_count++;
        end
        if (pixel_y !== want.y) begin
          $error("pixel_y: expected %0d, got %0d", want.y, pixel_y);
          mismatch_count++;
        end
        if (pixel_address !== want.addr) begin
          $error("pixel_address: expected %0h, got %0h", want.addr, pixel_address);
          mismatch_count++;
        end
        if (pixel_color !== want.color) begin
          $error("pixel_color: expected %06h, got %06h", want.color, pixel_color);
          mismatch_count++;
        end
        if (last_pixel !== want.last) begin
          $error("last_pixel: expected %0b, got %0b", want.last, last_pixel);
          mismatch_count++;
        end
      end
    end
  end

  // Field extremes, every kind of character and the wrap cases, at the reset width
  task automatic test_directed_cases();
    source_gaps_on = 1'b1;
    sink_stalls_on = 1'b1;
    send_char(make_item("A", 1'b1, 16'h0000, 16'h0000, 24'hFFFFFF));
    send_char(make_item("8", 1'b0, 16'hFFFF, 16'hFFFF, 24'h000000));
    send_char(make_item(CHAR_SPACE, 1'b0, 16'h5A5A, 16'hA5A5, 24'h123456));
    send_char(make_item(CHAR_LOWER_A, 1'b0, 16'h0000, 16'h0000, 24'h654321));
    send_char(make_item(CHAR_TOP, 1'b0, 16'hFFFF, 16'h0000, 24'hABCDEF));
    send_char(make_item(CHAR_NUL, 1'b0, 16'h0000, 16'hFFFF, 24'hFEDCBA));
    send_char(make_item(CHAR_NEWLINE, 1'b0, 16'h1234, 16'h4321, 24'h0F0F0F));
    send_char(make_item(".", 1'b0, 16'h0000, 16'h0000, 24'hF0F0F0));
    // Start flag on a newline: origin first, then down one line
    send_char(make_item(CHAR_NEWLINE, 1'b1, 16'd100, 16'd200, 24'h00FF00));
    send_char(make_item("!", 1'b0, 16'h0000, 16'h0000, 24'hFF0000));
    // Glyphs straddling the top of the coordinate range
    send_char(make_item("W", 1'b1, 16'hFFFE, 16'hFFFD, 24'h5A5A5A));
    send_char(make_item("M", 1'b0, 16'h0000, 16'h0000, 24'hA5A5A5));
    send_char(make_item(CHAR_NEWLINE, 1'b0, 16'h0000, 16'h0000, 24'h000001));
    send_char(make_item("-", 1'b0, 16'h0000, 16'h0000, 24'h800000));
    send_char(make_item(",", 1'b1, 16'hFFFF, 16'hFFFF, 24'h800001));
    send_char(make_item("[", 1'b0, 16'h0001, 16'h0001, 24'h7FFFFE));
    send_char(make_item("]", 1'b0, 16'h8000, 16'h8000, 24'h0000FF));
    send_char(make_item(":", 1'b0, 16'h7FFF, 16'h7FFF, 24'hFFFF00));
    send_char(make_item("Q", 1'b0, 16'hC3C3, 16'h3C3C, 24'h00FFFF));
    send_char(make_item("0", 1'b0, 16'h0000, 16'h0000, 24'hFF00FF));
    wait_for_pixels();
  endtask

  // Width register at 1 and at its maximum, then 16'h8000, a random value and back to the reset value
  task automatic test_image_widths();
    logic [WIDTH_BITS-1:0] widths [5];
    widths = '{16'd1, 16'hFFFF, 16'h8000, WIDTH_BITS'($urandom_range(2, 16'hFFFE)),
               IMAGE_WIDTH_RESET};
    foreach (widths[i]) begin
      write_image_width(widths[i]);
      send_char(make_item("H", 1'b1, random_origin(), random_origin(), color_t'($urandom())));
      send_char(make_item("I", 1'b0, coord_t'($urandom()), coord_t'($urandom()),
                          color_t'($urandom())));
      send_char(make_item("8", 1'b1, 16'hFFFF, 16'hFFFF, color_t'($urandom())));
    end
    wait_for_pixels();
  endtask

  // Hold the output off for a long stretch while characters keep coming, so
  // the job queue fills and the input stalls; then drain.
  task automatic test_back_pressure();
    source_gaps_on = 1'b0;
    sink_hold_req  = 1'b1;
    send_char(make_item("8", 1'b1, random_origin(), random_origin(), color_t'($urandom())));
    for (int i = 0; i < 11; i++) begin
      send_char(make_item(font_rows[$urandom_range(0, FONT_SIZE - 1)][42:35], 1'b0,
                          coord_t'($urandom()), coord_t'($urandom()),
                          color_t'($urandom())));
    end
    source_gaps_on = 1'b1;
    wait_for_pixels();
  endtask

  // Random text: a quiet opening stretch, then idling on both sides, with
  // width changes and, now and then, full drains between strings.
  task automatic test_random_text();
    int sent;
    int next_width_change;
    sent              = 0;
    next_width_change = 45;
    source_gaps_on    = 1'b0;
    sink_stalls_on    = 1'b0;
    while (sent < RANDOM_ITEMS) begin
      if (sent >= QUIET_ITEMS) begin
        source_gaps_on = 1'b1;
        sink_stalls_on = 1'b1;
      end
      begin
        int length;
        length = $urandom_range(2, 12);
        send_random_string(length);
        sent += length;
      end
      if (sent >= next_width_change) begin
        write_image_width(WIDTH_BITS'($urandom_range(1, 16'hFFFF)));
        next_width_change += 45;
      end else if ($urandom_range(0, 99) < 10) begin
        wait_for_pixels();
      end
    end
    wait_for_pixels();
  endtask

  initial begin : run_tests
    clk            = 1'b0;
    rst            = 1'b1;
    cfg_write_en   = 1'b0;
    cfg_write_data = '0;
    in_valid       = 1'b0;
    char_code      = '0;
    start_string   = 1'b0;
    origin_x       = '0;
    origin_y       = '0;
    ink_color      = '0;
    source_gaps_on = 1'b0;
    sink_stalls_on = 1'b0;
    sink_hold_req  = 1'b0;
    mismatch_count = 0;
    pixels_checked = 0;
    chars_sent     = 0;
    width_writes   = 0;
    pen_x          = '0;
    pen_y          = '0;
    margin_x       = '0;
    row_pitch      = IMAGE_WIDTH_RESET;

    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_directed_cases();
    test_image_widths();
    test_back_pressure();
    test_random_text();

    $display("Drew %0d characters into %0d checked pixel writes over %0d width settings,",
             chars_sent, pixels_checked, width_writes);
    $display("with wrapping origins, a long output hold-off and random idling on both sides.");
    if (mismatch_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  initial begin : watchdog
    #(TIMEOUT_NS);
    $display("RESULT: ERROR");
    $finish;
  end

endmodule
